// ===== hw/rtl/thresholded_intensity_centroid_defines.svh =====
// Assertion macros shared by the checker of the centroid block.
// Included by files that assert; holds no logic of its own.
`ifndef THRESHOLDED_INTENSITY_CENTROID_DEFINES_SVH
`define THRESHOLDED_INTENSITY_CENTROID_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tic_pkg.sv =====
// Package of the thresholded intensity centroid block.
// Holds widths, reset values, register indexes, sequencer states and types.
package tic_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W      = 8;
    localparam int INT_W     = 10;
    localparam int THR_W     = 10;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SIZE_W    = 13;
    localparam int POS_W     = 12;
    localparam int PROD_W    = INT_W + POS_W;
    localparam int MASS_W    = 34;
    localparam int MOM_W     = 46;
    localparam int PIX_W     = 20;
    localparam int FRAC_W    = 8;
    localparam int NORM_W    = 16;
    localparam int SAT_SH    = PIX_W - FRAC_W;
    localparam int STEP_W    = 5;

    localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(70);
    localparam logic [CFG_W-1:0]  WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0]  HEIGHT_RESET = CFG_W'(480);
    localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);
    localparam logic [POS_W-1:0]  ROW_LAST     = POS_W'(MAX_HEIGHT - 1);

    localparam logic [PIX_W-1:0]  PIX_MAX  = '1;
    localparam logic [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};

    localparam logic [STEP_W-1:0] STEPS_PIX  = STEP_W'(PIX_W);
    localparam logic [STEP_W-1:0] STEPS_NORM = STEP_W'(NORM_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_X_CHK,
        ST_X_DIV,
        ST_Y_CHK,
        ST_Y_DIV,
        ST_XN_CHK,
        ST_XN_DIV,
        ST_YN_CHK,
        ST_YN_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

// ===== hw/rtl/tic_div.sv =====
// Shared restoring divider of the centroid block, one quotient bit per cycle.
// Depends on tic_pkg for widths and the request type.
module tic_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tic_pkg::t_div_req           i_req,
    input  logic [tic_pkg::MASS_W-1:0]  i_rem_init,
    input  logic [tic_pkg::PIX_W-1:0]   i_low,
    input  logic [tic_pkg::MASS_W-1:0]  i_den,
    output logic                        o_done,
    output logic [tic_pkg::PIX_W-1:0]   o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [tic_pkg::STEP_W-1:0]    r_cnt;
    logic [tic_pkg::MASS_W-1:0]    r_rem;
    logic [tic_pkg::MASS_W-1:0]    r_den;
    logic [tic_pkg::PIX_W-1:0]     r_q;
    logic [tic_pkg::MASS_W:0]      s_trial;
    logic [tic_pkg::MASS_W:0]      s_diff;
    logic                          s_ge;

    assign s_trial = {r_rem, r_q[tic_pkg::PIX_W-1]};
    assign s_ge    = s_trial >= {1'b0, r_den};
    assign s_diff  = s_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == tic_pkg::STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - tic_pkg::STEP_W'(1);
                if (r_cnt == tic_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_rem_init;
            r_q   <= i_low;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= s_ge ? s_diff[tic_pkg::MASS_W-1:0] : s_trial[tic_pkg::MASS_W-1:0];
            r_q   <= {r_q[tic_pkg::PIX_W-2:0], s_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/thresholded_intensity_centroid.sv =====
// Top level of the thresholded intensity centroid block: pixel sums,
// frame-end sequencer and result register. Depends on tic_pkg and tic_div.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   red, green, blue, last_pixel
//   out      output     o_out_valid / i_out_stall centroid, normalized, flag
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A pixel that does not end the frame is taken without stalling the input.
// The last pixel holds the input: each of the four divisions has a check state that
// starts the divider, its steps (20 for a pixel centroid, 16 for a normalized value)
// and a wait state that collects the quotient, and the done state loads the result.
// A saturated value skips its steps. An empty frame goes from its first check to done.
// Reset is synchronous and clears sums. A stalled result waits in its register
// while the next frame streams in, and that frame's end waits for the register.
module thresholded_intensity_centroid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tic_pkg::CH_W-1:0]      i_red,
    input  logic [tic_pkg::CH_W-1:0]      i_green,
    input  logic [tic_pkg::CH_W-1:0]      i_blue,
    input  logic                          i_last_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tic_pkg::PIX_W-1:0]     o_x_cog_pixels,
    output logic [tic_pkg::PIX_W-1:0]     o_y_cog_pixels,
    output logic signed [tic_pkg::NORM_W-1:0] o_x_normalized,
    output logic signed [tic_pkg::NORM_W-1:0] o_y_normalized,
    output logic                          o_no_bright_pixel,
    input  logic                          i_cfg_we,
    input  logic [tic_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tic_pkg::CFG_W-1:0]     i_cfg_data
);

    tic_pkg::t_state              r_state;
    tic_pkg::t_state              n_state;

    logic [tic_pkg::THR_W-1:0]    r_thr;
    logic [tic_pkg::CFG_W-1:0]    r_width;
    logic [tic_pkg::CFG_W-1:0]    r_height;
    logic [tic_pkg::POS_W-1:0]    r_col;
    logic [tic_pkg::POS_W-1:0]    r_row;
    logic [tic_pkg::MASS_W-1:0]   r_mass;
    logic [tic_pkg::MOM_W-1:0]    r_col_mom;
    logic [tic_pkg::MOM_W-1:0]    r_row_mom;

    logic [tic_pkg::PIX_W-1:0]    r_x_pix;
    logic [tic_pkg::PIX_W-1:0]    r_y_pix;
    logic [tic_pkg::NORM_W-1:0]   r_x_norm;
    logic [tic_pkg::NORM_W-1:0]   r_y_norm;
    logic                         r_empty;

    logic                         r_out_valid;
    logic [tic_pkg::PIX_W-1:0]    r_out_x_pix;
    logic [tic_pkg::PIX_W-1:0]    r_out_y_pix;
    logic [tic_pkg::NORM_W-1:0]   r_out_x_norm;
    logic [tic_pkg::NORM_W-1:0]   r_out_y_norm;
    logic                         r_out_empty;

    logic [tic_pkg::SIZE_W-1:0]   s_w_eff;
    logic [tic_pkg::SIZE_W-1:0]   s_h_eff;
    logic [tic_pkg::INT_W-1:0]    s_inten;
    logic                         s_hit;
    logic [tic_pkg::PROD_W-1:0]   s_prod_col;
    logic [tic_pkg::PROD_W-1:0]   s_prod_row;
    logic [tic_pkg::POS_W:0]      s_col_next;
    logic                         s_accept;
    logic                         s_out_free;
    logic                         s_load;
    logic                         s_empty;
    logic                         s_x_sat;
    logic                         s_y_sat;
    logic                         s_xn_sat;
    logic                         s_yn_sat;

    tic_pkg::t_div_req            s_div_req;
    logic [tic_pkg::MASS_W-1:0]   s_div_rem;
    logic [tic_pkg::PIX_W-1:0]    s_div_low;
    logic [tic_pkg::MASS_W-1:0]   s_div_den;
    logic                         s_div_done;
    logic [tic_pkg::PIX_W-1:0]    s_div_quot;
    logic [tic_pkg::NORM_W-1:0]   s_norm_q;

    always_comb begin
        if (r_width == '0) begin
            s_w_eff = tic_pkg::SIZE_W'(1);
        end else if (r_width > tic_pkg::WIDTH_MAX) begin
            s_w_eff = tic_pkg::WIDTH_MAX;
        end else begin
            s_w_eff = r_width;
        end
        if (r_height == '0) begin
            s_h_eff = tic_pkg::SIZE_W'(1);
        end else if (r_height > tic_pkg::HEIGHT_MAX) begin
            s_h_eff = tic_pkg::HEIGHT_MAX;
        end else begin
            s_h_eff = r_height;
        end
    end

    assign s_inten = tic_pkg::INT_W'(i_red) + tic_pkg::INT_W'(i_green)
                   + tic_pkg::INT_W'(i_blue);
    assign s_hit      = s_inten >= r_thr;
    assign s_prod_col = tic_pkg::PROD_W'(s_inten) * tic_pkg::PROD_W'(r_col);
    assign s_prod_row = tic_pkg::PROD_W'(s_inten) * tic_pkg::PROD_W'(r_row);
    assign s_col_next = {1'b0, r_col} + (tic_pkg::POS_W+1)'(1);

    assign o_in_stall = (r_state != tic_pkg::ST_ACC);
    assign s_accept   = i_in_valid && !o_in_stall;
    assign s_out_free = !r_out_valid || !i_out_stall;

    assign s_empty  = (r_mass == '0);
    assign s_x_sat  = r_col_mom >= {r_mass, {tic_pkg::SAT_SH{1'b0}}};
    assign s_y_sat  = r_row_mom >= {r_mass, {tic_pkg::SAT_SH{1'b0}}};
    assign s_xn_sat = {1'b0, r_x_pix} >= {s_w_eff, {tic_pkg::FRAC_W{1'b0}}};
    assign s_yn_sat = {1'b0, r_y_pix} >= {s_h_eff, {tic_pkg::FRAC_W{1'b0}}};
    assign s_norm_q = s_div_quot[tic_pkg::NORM_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tic_pkg::ST_ACC: begin
                if (s_accept && i_last_pixel) begin
                    n_state = tic_pkg::ST_X_CHK;
                end
            end
            tic_pkg::ST_X_CHK: begin
                priority if (s_empty) begin
                    n_state = tic_pkg::ST_DONE;
                end else if (s_x_sat) begin
                    n_state = tic_pkg::ST_Y_CHK;
                end else begin
                    n_state = tic_pkg::ST_X_DIV;
                end
            end
            tic_pkg::ST_X_DIV: begin
                if (s_div_done) begin
                    n_state = tic_pkg::ST_Y_CHK;
                end
            end
            tic_pkg::ST_Y_CHK: begin
                n_state = s_y_sat ? tic_pkg::ST_XN_CHK : tic_pkg::ST_Y_DIV;
            end
            tic_pkg::ST_Y_DIV: begin
                if (s_div_done) begin
                    n_state = tic_pkg::ST_XN_CHK;
                end
            end
            tic_pkg::ST_XN_CHK: begin
                n_state = s_xn_sat ? tic_pkg::ST_YN_CHK : tic_pkg::ST_XN_DIV;
            end
            tic_pkg::ST_XN_DIV: begin
                if (s_div_done) begin
                    n_state = tic_pkg::ST_YN_CHK;
                end
            end
            tic_pkg::ST_YN_CHK: begin
                n_state = s_yn_sat ? tic_pkg::ST_DONE : tic_pkg::ST_YN_DIV;
            end
            tic_pkg::ST_YN_DIV: begin
                if (s_div_done) begin
                    n_state = tic_pkg::ST_DONE;
                end
            end
            tic_pkg::ST_DONE: begin
                if (s_out_free) begin
                    n_state = tic_pkg::ST_ACC;
                end
            end
            default: begin
                n_state = tic_pkg::ST_ACC;
            end
        endcase
    end

    always_comb begin
        s_div_req.start = 1'b0;
        s_div_req.steps = tic_pkg::STEPS_PIX;
        s_div_rem       = '0;
        s_div_low       = '0;
        s_div_den       = r_mass;
        s_load          = 1'b0;
        unique case (r_state)
            tic_pkg::ST_X_CHK: begin
                s_div_req.start = !s_empty && !s_x_sat;
                s_div_rem = r_col_mom[tic_pkg::MOM_W-1:tic_pkg::SAT_SH];
                s_div_low = {r_col_mom[tic_pkg::SAT_SH-1:0], {tic_pkg::FRAC_W{1'b0}}};
            end
            tic_pkg::ST_Y_CHK: begin
                s_div_req.start = !s_y_sat;
                s_div_rem = r_row_mom[tic_pkg::MOM_W-1:tic_pkg::SAT_SH];
                s_div_low = {r_row_mom[tic_pkg::SAT_SH-1:0], {tic_pkg::FRAC_W{1'b0}}};
            end
            tic_pkg::ST_XN_CHK: begin
                s_div_req.start = !s_xn_sat;
                s_div_req.steps = tic_pkg::STEPS_NORM;
                s_div_rem = tic_pkg::MASS_W'(r_x_pix[tic_pkg::PIX_W-1:tic_pkg::FRAC_W]);
                s_div_low = {r_x_pix[tic_pkg::FRAC_W-1:0], {tic_pkg::SAT_SH{1'b0}}};
                s_div_den = tic_pkg::MASS_W'(s_w_eff);
            end
            tic_pkg::ST_YN_CHK: begin
                s_div_req.start = !s_yn_sat;
                s_div_req.steps = tic_pkg::STEPS_NORM;
                s_div_rem = tic_pkg::MASS_W'(r_y_pix[tic_pkg::PIX_W-1:tic_pkg::FRAC_W]);
                s_div_low = {r_y_pix[tic_pkg::FRAC_W-1:0], {tic_pkg::SAT_SH{1'b0}}};
                s_div_den = tic_pkg::MASS_W'(s_h_eff);
            end
            tic_pkg::ST_DONE: begin
                s_load = s_out_free;
            end
            default: begin
                s_load = 1'b0;
            end
        endcase
    end

    tic_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (s_div_req),
        .i_rem_init (s_div_rem),
        .i_low      (s_div_low),
        .i_den      (s_div_den),
        .o_done     (s_div_done),
        .o_quot     (s_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tic_pkg::ST_ACC;
            r_thr       <= tic_pkg::THR_RESET;
            r_width     <= tic_pkg::WIDTH_RESET;
            r_height    <= tic_pkg::HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_mass      <= '0;
            r_col_mom   <= '0;
            r_row_mom   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (tic_pkg::t_reg_idx'(i_cfg_index))
                    tic_pkg::REG_THRESHOLD: r_thr    <= i_cfg_data[tic_pkg::THR_W-1:0];
                    tic_pkg::REG_WIDTH:     r_width  <= i_cfg_data;
                    tic_pkg::REG_HEIGHT:    r_height <= i_cfg_data;
                    default: begin
                        r_thr <= r_thr;
                    end
                endcase
            end

            if (s_accept) begin
                if (s_hit) begin
                    r_mass    <= r_mass + tic_pkg::MASS_W'(s_inten);
                    r_col_mom <= r_col_mom + tic_pkg::MOM_W'(s_prod_col);
                    r_row_mom <= r_row_mom + tic_pkg::MOM_W'(s_prod_row);
                end
                if (i_last_pixel) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (s_col_next >= s_w_eff) begin
                    r_col <= '0;
                    if (r_row < tic_pkg::ROW_LAST) begin
                        r_row <= r_row + tic_pkg::POS_W'(1);
                    end
                end else begin
                    r_col <= s_col_next[tic_pkg::POS_W-1:0];
                end
            end

            if (s_load) begin
                r_mass    <= '0;
                r_col_mom <= '0;
                r_row_mom <= '0;
            end

            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tic_pkg::ST_X_CHK: begin
                r_empty <= s_empty;
                if (s_empty) begin
                    r_x_pix  <= '0;
                    r_y_pix  <= '0;
                    r_x_norm <= '0;
                    r_y_norm <= '0;
                end else if (s_x_sat) begin
                    r_x_pix <= tic_pkg::PIX_MAX;
                end
            end
            tic_pkg::ST_X_DIV: begin
                if (s_div_done) begin
                    r_x_pix <= s_div_quot;
                end
            end
            tic_pkg::ST_Y_CHK: begin
                if (s_y_sat) begin
                    r_y_pix <= tic_pkg::PIX_MAX;
                end
            end
            tic_pkg::ST_Y_DIV: begin
                if (s_div_done) begin
                    r_y_pix <= s_div_quot;
                end
            end
            tic_pkg::ST_XN_CHK: begin
                if (s_xn_sat) begin
                    r_x_norm <= tic_pkg::NORM_MAX;
                end
            end
            tic_pkg::ST_XN_DIV: begin
                if (s_div_done) begin
                    r_x_norm <= {~s_norm_q[tic_pkg::NORM_W-1], s_norm_q[tic_pkg::NORM_W-2:0]};
                end
            end
            tic_pkg::ST_YN_CHK: begin
                if (s_yn_sat) begin
                    r_y_norm <= tic_pkg::NORM_MAX;
                end
            end
            tic_pkg::ST_YN_DIV: begin
                if (s_div_done) begin
                    r_y_norm <= {~s_norm_q[tic_pkg::NORM_W-1], s_norm_q[tic_pkg::NORM_W-2:0]};
                end
            end
            default: begin
                r_empty <= r_empty;
            end
        endcase

        if (s_load) begin
            r_out_x_pix  <= r_x_pix;
            r_out_y_pix  <= r_y_pix;
            r_out_x_norm <= r_x_norm;
            r_out_y_norm <= r_y_norm;
            r_out_empty  <= r_empty;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_x_cog_pixels    = r_out_x_pix;
    assign o_y_cog_pixels    = r_out_y_pix;
    assign o_x_normalized    = r_out_x_norm;
    assign o_y_normalized    = r_out_y_norm;
    assign o_no_bright_pixel = r_out_empty;

endmodule

// ===== hw/rtl/tic_checker.sv =====
// Port-level checker of the thresholded intensity centroid block, with its bind.
// Depends on tic_pkg and the assertion macros of the defines header.
`include "thresholded_intensity_centroid_defines.svh"

module tic_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_last_pixel,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [tic_pkg::PIX_W-1:0]     o_x_cog_pixels,
    input logic [tic_pkg::PIX_W-1:0]     o_y_cog_pixels,
    input logic [tic_pkg::NORM_W-1:0]    o_x_normalized,
    input logic [tic_pkg::NORM_W-1:0]    o_y_normalized,
    input logic                          o_no_bright_pixel
);

    logic s_in_last;
    logic s_empty_zero;

    assign s_in_last    = i_in_valid && !o_in_stall && i_last_pixel;
    assign s_empty_zero = (o_x_cog_pixels == '0) && (o_y_cog_pixels == '0)
                        && (o_x_normalized == '0) && (o_y_normalized == '0);

    `TIC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_x_cog_pixels) && $stable(o_y_cog_pixels) && $stable(o_x_normalized) && $stable(o_y_normalized) && $stable(o_no_bright_pixel), "stalled result item changed")
    `TIC_ASSERT_NOW(a_empty_zero, o_out_valid && o_no_bright_pixel, s_empty_zero, "empty frame item carries nonzero coordinates")
    `TIC_ASSERT_NEXT(a_last_busy, s_in_last, o_in_stall, "input taken right after the last pixel of a frame")
    `TIC_ASSERT_NOW(a_result_after_work, $rose(o_out_valid), $past(o_in_stall), "result item appeared without frame-end work")

endmodule

bind thresholded_intensity_centroid tic_checker u_tic_checker (.*);
